@@ rtl/dcsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsp_pkg
// Shared types and constants for the DIMACS CNF stream parser.
// ----------------------------------------------------------------------------
package dcsp_pkg;

	localparam int ACC_W   = 33;
	localparam int VARS_W  = 24;
	localparam int CLS_W   = 32;
	localparam int LIT_W   = 25;
	localparam int SUM_W   = ACC_W + 4;

	localparam logic [ACC_W-1:0] ACC_CAP     = 33'h1_FFFF_FFFF;
	localparam logic [ACC_W-1:0] MAX_VARS    = 33'd16777215;
	localparam logic [ACC_W-1:0] MAX_CLAUSES = 33'd4294967295;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [2:0] KIND_LIT    = 3'd0;
	localparam logic [2:0] KIND_CLAUSE = 3'd1;
	localparam logic [2:0] KIND_HEADER = 3'd2;
	localparam logic [2:0] KIND_DONE   = 3'd3;
	localparam logic [2:0] KIND_ERROR  = 3'd4;

	localparam logic [3:0] ERR_EOF_HEADER   = 4'd0;
	localparam logic [3:0] ERR_EOF_HCOMMENT = 4'd1;
	localparam logic [3:0] ERR_EOF_BCOMMENT = 4'd2;
	localparam logic [3:0] ERR_BAD_HEADER   = 4'd3;
	localparam logic [3:0] ERR_NEG_NO_DIGIT = 4'd4;
	localparam logic [3:0] ERR_EXPECT_LIT   = 4'd5;
	localparam logic [3:0] ERR_LIT_RANGE    = 4'd6;
	localparam logic [3:0] ERR_TOO_MANY     = 4'd7;
	localparam logic [3:0] ERR_COUNT_MISS   = 4'd8;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [4:0] {
		PH_HSTART,
		PH_HCOMMENT,
		PH_P1,
		PH_P2,
		PH_P3,
		PH_P4,
		PH_P5,
		PH_VFIRST,
		PH_VMORE,
		PH_CFIRST,
		PH_CMORE,
		PH_BODY,
		PH_BCOMMENT,
		PH_NEG,
		PH_LIT,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [LIT_W-1:0]  lit;
		logic [VARS_W-1:0] vars;
		logic [CLS_W-1:0]  cls;
		logic [3:0]        err;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic res_t make_res(input logic [2:0] kind);
		res_t r;
		r      = '0;
		r.kind = kind;
		return r;
	endfunction

	function automatic res_t make_err(input logic [3:0] code);
		res_t r;
		r      = '0;
		r.kind = KIND_ERROR;
		r.err  = code;
		return r;
	endfunction

endpackage

@@ rtl/dcsp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsp_front
// Parser front end: classifies each byte and produces up to two results.
// ----------------------------------------------------------------------------
module dcsp_front import dcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] text_byte,
	input  logic       at_end,
	output push_t      push
);

	phase_t             phase_q, phase_d;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic               neg_q, neg_d;
	logic [VARS_W-1:0]  vars_q, vars_d;
	logic [CLS_W-1:0]   cls_q, cls_d;
	logic [ACC_W-1:0]   seen_q, seen_d;

	logic               is_digit;
	logic [3:0]         dval;
	logic [SUM_W-1:0]   acc_sum;
	logic [ACC_W-1:0]   acc_next;
	logic [7:0]         hdr_ch;

	logic [CLS_W-1:0]   cls_eff;
	logic [ACC_W-1:0]   seen_eff;
	logic               b_emit;
	res_t               b_res;
	phase_t             b_phase;
	logic               b_neg;
	logic [ACC_W-1:0]   b_acc;
	logic               b_inc;
	logic               ws;

	logic [1:0]         n;
	res_t               r0, r1;

	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign dval     = 4'(text_byte - CH_ZERO);
	assign acc_sum  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + SUM_W'(dval);
	assign acc_next = (acc_sum > SUM_W'(ACC_CAP)) ? ACC_CAP : acc_sum[ACC_W-1:0];
	assign ws       = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
	                  (text_byte == CH_CR) || (text_byte == CH_LF);

	always_comb begin
		unique case (phase_q)
			PH_P1:   hdr_ch = CH_SPACE;
			PH_P2:   hdr_ch = CH_C;
			PH_P3:   hdr_ch = CH_N;
			PH_P4:   hdr_ch = CH_F;
			default: hdr_ch = CH_SPACE;
		endcase
	end

	always_comb begin
		if (phase_q == PH_CMORE) begin
			cls_eff  = acc_q[CLS_W-1:0];
			seen_eff = '0;
		end else begin
			cls_eff  = cls_q;
			seen_eff = seen_q;
		end
		b_emit  = 1'b0;
		b_res   = '0;
		b_phase = PH_BODY;
		b_neg   = neg_q;
		b_acc   = acc_q;
		b_inc   = 1'b0;
		if (at_end) begin
			b_emit = 1'b1;
			if (seen_eff != ACC_W'(cls_eff)) begin
				b_res   = make_err(ERR_COUNT_MISS);
				b_phase = PH_ERR;
			end else begin
				b_res   = make_res(KIND_DONE);
				b_phase = PH_DONE;
			end
		end else if (ws) begin
			b_phase = PH_BODY;
		end else if (text_byte == CH_C) begin
			b_phase = PH_BCOMMENT;
		end else if (text_byte == CH_ZERO) begin
			b_emit = 1'b1;
			if (seen_eff >= ACC_W'(cls_eff)) begin
				b_res   = make_err(ERR_TOO_MANY);
				b_phase = PH_ERR;
			end else begin
				b_inc = 1'b1;
				b_res = make_res(KIND_CLAUSE);
			end
		end else if (text_byte == CH_MINUS) begin
			b_neg   = 1'b1;
			b_phase = PH_NEG;
		end else if (is_digit) begin
			b_neg   = 1'b0;
			b_acc   = ACC_W'(dval);
			b_phase = PH_LIT;
		end else begin
			b_emit  = 1'b1;
			b_res   = make_err(ERR_EXPECT_LIT);
			b_phase = PH_ERR;
		end
	end

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		vars_d  = vars_q;
		cls_d   = cls_q;
		seen_d  = seen_q;
		n       = 2'd0;
		r0      = '0;
		r1      = '0;
		unique case (phase_q)
			PH_HSTART: begin
				if (at_end) begin
					n = 2'd1; r0 = make_err(ERR_EOF_HEADER); phase_d = PH_ERR;
				end else if (text_byte == CH_C) begin
					phase_d = PH_HCOMMENT;
				end else if (text_byte == CH_P) begin
					phase_d = PH_P1;
				end else begin
					n = 2'd1; r0 = make_err(ERR_BAD_HEADER); phase_d = PH_ERR;
				end
			end
			PH_HCOMMENT: begin
				if (at_end) begin
					n = 2'd1; r0 = make_err(ERR_EOF_HCOMMENT); phase_d = PH_ERR;
				end else if (text_byte == CH_LF) begin
					phase_d = PH_HSTART;
				end
			end
			PH_P1, PH_P2, PH_P3, PH_P4, PH_P5: begin
				if (at_end || text_byte != hdr_ch) begin
					n = 2'd1; r0 = make_err(ERR_BAD_HEADER); phase_d = PH_ERR;
				end else if (phase_q == PH_P5) begin
					phase_d = PH_VFIRST;
				end else begin
					phase_d = phase_t'(phase_q + 5'd1);
				end
			end
			PH_VFIRST, PH_CFIRST: begin
				if (at_end) begin
					n = 2'd1; r0 = make_err(ERR_EOF_HEADER); phase_d = PH_ERR;
				end else if (!is_digit) begin
					n = 2'd1; r0 = make_err(ERR_BAD_HEADER); phase_d = PH_ERR;
				end else begin
					acc_d   = ACC_W'(dval);
					phase_d = (phase_q == PH_VFIRST) ? PH_VMORE : PH_CMORE;
				end
			end
			PH_VMORE: begin
				if (at_end) begin
					n = 2'd1; r0 = make_err(ERR_EOF_HEADER); phase_d = PH_ERR;
				end else if (is_digit) begin
					acc_d = acc_next;
				end else if (acc_q > MAX_VARS) begin
					n = 2'd1; r0 = make_err(ERR_BAD_HEADER); phase_d = PH_ERR;
				end else begin
					vars_d  = acc_q[VARS_W-1:0];
					phase_d = PH_CFIRST;
				end
			end
			PH_CMORE: begin
				if (!at_end && is_digit) begin
					acc_d = acc_next;
				end else if (acc_q > MAX_CLAUSES) begin
					n = 2'd1; r0 = make_err(ERR_BAD_HEADER); phase_d = PH_ERR;
				end else begin
					cls_d   = acc_q[CLS_W-1:0];
					r0      = make_res(KIND_HEADER);
					r0.vars = vars_q;
					r0.cls  = acc_q[CLS_W-1:0];
					r1      = b_res;
					n       = b_emit ? 2'd2 : 2'd1;
					phase_d = b_phase;
					neg_d   = b_neg;
					acc_d   = b_acc;
					seen_d  = seen_eff + ACC_W'(b_inc);
				end
			end
			PH_BODY: begin
				r0      = b_res;
				n       = b_emit ? 2'd1 : 2'd0;
				phase_d = b_phase;
				neg_d   = b_neg;
				acc_d   = b_acc;
				seen_d  = seen_eff + ACC_W'(b_inc);
			end
			PH_BCOMMENT: begin
				if (at_end) begin
					n = 2'd1; r0 = make_err(ERR_EOF_BCOMMENT); phase_d = PH_ERR;
				end else if (text_byte == CH_LF) begin
					phase_d = PH_BODY;
				end
			end
			PH_NEG: begin
				if (at_end || !is_digit) begin
					n = 2'd1; r0 = make_err(ERR_NEG_NO_DIGIT); phase_d = PH_ERR;
				end else begin
					acc_d   = ACC_W'(dval);
					phase_d = PH_LIT;
				end
			end
			PH_LIT: begin
				if (!at_end && is_digit) begin
					acc_d = acc_next;
				end else if (acc_q == '0 || acc_q > ACC_W'(vars_q)) begin
					n = 2'd1; r0 = make_err(ERR_LIT_RANGE); phase_d = PH_ERR;
				end else begin
					r0      = make_res(KIND_LIT);
					r0.lit  = LIT_W'({acc_q[LIT_W-2:0] - (LIT_W-1)'(1), neg_q});
					r1      = b_res;
					n       = b_emit ? 2'd2 : 2'd1;
					phase_d = b_phase;
					neg_d   = b_neg;
					acc_d   = b_acc;
					seen_d  = seen_eff + ACC_W'(b_inc);
				end
			end
			PH_DONE, PH_ERR: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = PH_ERR;
			end
		endcase
		if (n == 2'd1) r0.last = 1'b1;
		if (n == 2'd2) r1.last = 1'b1;
	end

	assign push.cnt = fire ? n : 2'd0;
	assign push.r0  = r0;
	assign push.r1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HSTART;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			vars_q  <= '0;
			cls_q   <= '0;
			seen_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			vars_q  <= vars_d;
			cls_q   <= cls_d;
			seen_q  <= seen_d;
		end
	end

endmodule

@@ rtl/dcsp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsp_queue
// Result queue: takes up to two results a cycle, hands out one a cycle while pop is high.
// ----------------------------------------------------------------------------
module dcsp_queue import dcsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  has_room,
	output logic  not_empty,
	output res_t  head
);

	res_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;
	logic [Q_AW-1:0] wr_p1;
	logic            do_pop;

	assign wr_p1     = wr_q + Q_AW'(1);
	assign not_empty = (cnt_q != '0);
	assign has_room  = (cnt_q <= Q_CW'(Q_DEPTH - 2));
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.cnt == 2'd2) mem_q[wr_p1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_AW'(push.cnt);
			if (do_pop) rd_q <= rd_q + Q_AW'(1);
			cnt_q <= cnt_q + Q_CW'(push.cnt) - Q_CW'(do_pop);
		end
	end

endmodule

@@ rtl/dimacs_cnf_stream_parser_top.sv @@
`timescale 1ns / 1ps
// Results: a result enters the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while the queue has room; a byte that causes two
// results puts both into the four-entry result queue behind the parser.
// Reset: arst_n clears the parser phase, counters and queue pointers at once.
// ----------------------------------------------------------------------------
// dimacs_cnf_stream_parser_top
// Streaming DIMACS CNF parser: parser front end feeding a result queue.
// ----------------------------------------------------------------------------
module dimacs_cnf_stream_parser_top import dcsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	output logic              text_ready,
	input  logic [7:0]        text_byte,
	input  logic              at_end,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        kind,
	output logic [LIT_W-1:0]  encoded_literal,
	output logic [VARS_W-1:0] variable_count,
	output logic [CLS_W-1:0]  clause_total,
	output logic [3:0]        error_code,
	output logic              last_of_run
);

	push_t push;
	res_t  head;
	logic  has_room;
	logic  fire;

	assign text_ready = has_room;
	assign fire       = text_valid && has_room;

	dcsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.text_byte (text_byte),
		.at_end    (at_end),
		.push      (push)
	);

	dcsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (result_ready),
		.has_room  (has_room),
		.not_empty (result_valid),
		.head      (head)
	);

	assign kind            = head.kind;
	assign encoded_literal = head.lit;
	assign variable_count  = head.vars;
	assign clause_total    = head.cls;
	assign error_code      = head.err;
	assign last_of_run     = head.last;

endmodule
